@@ hdl/ctok_pkg.sv @@
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, character codes and helper functions for the command line
// tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

    localparam int CTOK_LINE_CAPACITY = 256;
    localparam logic [3:0] CTOK_MAX_TOKENS = 4'd8;
    localparam logic [7:0] CTOK_LEAD_RESET = 8'h24;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef enum logic [2:0] {
        KIND_CHAR     = 3'd0,
        KIND_START    = 3'd1,
        KIND_LINE_OK  = 3'd2,
        KIND_UNTERM   = 3'd3,
        KIND_OVERLONG = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_CR   = 2'd1,
        HOLD_BSL  = 2'd2
    } t_hold;

    typedef struct packed {
        logic       line_is_command;
        logic       ignore_rest;
        logic       in_quotes;
        logic       in_token;
        logic [3:0] tokens_seen;
        t_hold      held;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        line_is_command: 1'b0,
        ignore_rest:     1'b0,
        in_quotes:       1'b0,
        in_token:        1'b0,
        tokens_seen:     4'd0,
        held:            HOLD_NONE
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_value;
        logic [2:0] token_index;
        logic [3:0] token_count;
    } t_result;

    // results caused by one input byte, loaded into the output buffer at once
    typedef struct packed {
        logic             load;
        logic [1:0]       cnt;
        t_result [0:2]    item;
    } t_res_set;

    typedef struct packed {
        t_line_state st;
        logic        start_em;
        logic        char_em;
    } t_feed;

    function automatic logic [2:0] ctok_idx(input logic [3:0] seen);
        logic [3:0] tm;
        tm = seen - 4'd1;
        return tm[2:0];
    endfunction

    function automatic t_result ctok_mk(input t_kind kind, input logic [7:0] ch,
                                        input logic [2:0] idx, input logic [3:0] cnt);
        t_result r;
        r.kind        = kind;
        r.char_value  = ch;
        r.token_index = idx;
        r.token_count = cnt;
        return r;
    endfunction

    // one ordinary content byte
    function automatic t_feed ctok_feed(input t_line_state st, input logic [7:0] b);
        t_feed f;
        logic  done;
        f.st       = st;
        f.start_em = 1'b0;
        f.char_em  = 1'b0;
        done       = 1'b0;
        if (!st.in_token) begin
            if (b == CH_SPACE) begin
                done = 1'b1;
            end else if (st.tokens_seen >= CTOK_MAX_TOKENS) begin
                f.st.ignore_rest = 1'b1;
                done             = 1'b1;
            end else begin
                f.st.tokens_seen = st.tokens_seen + 4'd1;
                f.st.in_token    = 1'b1;
                f.start_em       = 1'b1;
            end
        end
        if (!done) begin
            priority if (b == CH_QUOTE) begin
                f.st.in_quotes = !f.st.in_quotes;
            end else if (!f.st.in_quotes && b == CH_SPACE) begin
                f.st.in_token = 1'b0;
            end else if (f.st.in_quotes && b == CH_BSL) begin
                f.st.held = HOLD_BSL;
            end else begin
                f.char_em = 1'b1;
            end
        end
        return f;
    endfunction

endpackage

@@ hdl/command_line_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Shell-style quoted tokenizer for a received byte stream.
// ----------------------------------------------------------------------------
// A byte passes the core's input register and then the output buffer before its
// first result is offered. Throughput: one byte per cycle while the buffer can load;
// a byte with several results stalls the next until the single result port reaches its last.
// Reset (synchronous, active low): lead char returns to '$', line state and
//   both buffers clear, no result is pending.
module command_line_tokenizer_unit #(
    parameter int LINE_CAPACITY = ctok_pkg::CTOK_LINE_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_char_value,
    output logic [2:0] o_token_index,
    output logic [3:0] o_token_count,
    output logic       o_last_of_run
);
    import ctok_pkg::*;

    t_res_set set;
    t_result  item;
    logic     can_load;

    assign o_cfg_ready = 1'b1;

    ctok_core #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_can_load  (can_load),
        .o_set       (set)
    );

    ctok_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_set      (set),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (item),
        .o_last     (o_last_of_run)
    );

    assign o_kind        = item.kind;
    assign o_char_value  = item.char_value;
    assign o_token_index = item.token_index;
    assign o_token_count = item.token_count;

endmodule

@@ hdl/ctok_core.sv @@
// ----------------------------------------------------------------------------
// ctok_core
// Input register, line state and per-byte parse logic; hands the results of
// one byte to the output buffer as a set.
// ----------------------------------------------------------------------------
module ctok_core #(
    parameter int LINE_CAPACITY = ctok_pkg::CTOK_LINE_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_can_load,
    output ctok_pkg::t_res_set o_set
);
    import ctok_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAPACITY);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_CAPACITY - 1);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_lead;
    t_line_state       r_st;
    t_line_state       n_st;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [1:0]        n_cnt;
    t_result [0:2]     n_res;
    logic              consume;

    always_comb begin
        logic [7:0] b;
        logic       go;
        t_feed      f;
        b      = r_in_byte;
        n_st   = r_st;
        n_fill = r_fill;
        n_cnt  = 2'd0;
        n_res  = '0;
        go     = 1'b0;
        f      = '0;
        if (b == CH_LF) begin
            if (r_fill != '0 && r_st.line_is_command) begin
                if (!r_st.ignore_rest && r_st.held == HOLD_BSL) begin
                    n_res[n_cnt] = ctok_mk(KIND_CHAR, CH_BSL, ctok_idx(r_st.tokens_seen), 4'd0);
                    n_cnt        = n_cnt + 2'd1;
                end
                if (r_st.in_quotes) begin
                    n_res[n_cnt] = ctok_mk(KIND_UNTERM, 8'd0, 3'd0, 4'd0);
                end else begin
                    n_res[n_cnt] = ctok_mk(KIND_LINE_OK, 8'd0, 3'd0, r_st.tokens_seen);
                end
                n_cnt = n_cnt + 2'd1;
            end
            n_st   = LINE_CLEAR;
            n_fill = '0;
        end else if (r_fill < FILL_LIMIT) begin
            if (r_fill == '0) begin
                n_st.line_is_command = (b == r_lead);
            end
            n_fill = r_fill + FILL_W'(1);
            if (n_st.line_is_command && !n_st.ignore_rest) begin
                if (b == CH_NUL) begin
                    if (n_st.held == HOLD_BSL) begin
                        n_res[n_cnt] = ctok_mk(KIND_CHAR, CH_BSL,
                                               ctok_idx(n_st.tokens_seen), 4'd0);
                        n_cnt        = n_cnt + 2'd1;
                    end
                    n_st.held        = HOLD_NONE;
                    n_st.ignore_rest = 1'b1;
                end else begin
                    go = 1'b1;
                    unique case (n_st.held)
                        HOLD_BSL: begin
                            n_st.held = HOLD_NONE;
                            if (b == CH_QUOTE || b == CH_BSL) begin
                                n_res[n_cnt] = ctok_mk(KIND_CHAR, b,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                                go           = 1'b0;
                            end else begin
                                n_res[n_cnt] = ctok_mk(KIND_CHAR, CH_BSL,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                            end
                            n_cnt = n_cnt + 2'd1;
                        end
                        HOLD_CR: begin
                            n_st.held = HOLD_NONE;
                            f         = ctok_feed(n_st, CH_CR);
                            n_st      = f.st;
                            if (f.start_em) begin
                                n_res[n_cnt] = ctok_mk(KIND_START, 8'd0,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                                n_cnt        = n_cnt + 2'd1;
                            end
                            if (f.char_em) begin
                                n_res[n_cnt] = ctok_mk(KIND_CHAR, CH_CR,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                                n_cnt        = n_cnt + 2'd1;
                            end
                            if (n_st.ignore_rest) begin
                                go = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (go) begin
                        if (b == CH_CR) begin
                            n_st.held = HOLD_CR;
                        end else begin
                            f    = ctok_feed(n_st, b);
                            n_st = f.st;
                            if (f.start_em && n_cnt != 2'd3) begin
                                n_res[n_cnt] = ctok_mk(KIND_START, 8'd0,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                                n_cnt        = n_cnt + 2'd1;
                            end
                            if (f.char_em && n_cnt != 2'd3) begin
                                n_res[n_cnt] = ctok_mk(KIND_CHAR, b,
                                                       ctok_idx(n_st.tokens_seen), 4'd0);
                                n_cnt        = n_cnt + 2'd1;
                            end
                        end
                    end
                end
            end
        end else begin
            // overlong line: drop it and resync on the next byte
            if (r_st.line_is_command) begin
                n_res[n_cnt] = ctok_mk(KIND_OVERLONG, 8'd0, 3'd0, 4'd0);
                n_cnt        = n_cnt + 2'd1;
            end
            n_st   = LINE_CLEAR;
            n_fill = '0;
        end
    end

    // a byte with no results never waits for the output side
    assign consume = r_in_vld && (n_cnt == 2'd0 || i_can_load);
    assign o_ready = !r_in_vld || consume;

    assign o_set = '{load: consume && n_cnt != 2'd0, cnt: n_cnt, item: n_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_lead   <= CTOK_LEAD_RESET;
            r_st     <= LINE_CLEAR;
            r_fill   <= '0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (i_cfg_valid) begin
                r_lead <= i_cfg_data;
            end
            if (consume) begin
                r_st   <= n_st;
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule

@@ hdl/ctok_obuf.sv @@
// ----------------------------------------------------------------------------
// ctok_obuf
// Output buffer: holds the up to three results of one byte and shifts them
// out one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ctok_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctok_pkg::t_res_set i_set,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output ctok_pkg::t_result  o_item,
    output logic               o_last
);
    import ctok_pkg::*;

    logic [1:0]    r_cnt;
    t_result [0:2] r_item;
    logic          pop;

    assign o_valid    = r_cnt != 2'd0;
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_item     = r_item[0];
    assign o_last     = r_cnt == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_set.load) begin
            r_cnt <= i_set.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_set.load) begin
            r_item <= i_set.item;
        end else if (pop) begin
            r_item[0] <= r_item[1];
            r_item[1] <= r_item[2];
        end
    end

endmodule

@@ hdl/ctok_checker.sv @@
// ----------------------------------------------------------------------------
// ctok_props
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module ctok_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_kind,
    input logic [2:0] o_token_index,
    input logic [3:0] o_token_count,
    input logic       o_last_of_run
);
    import ctok_pkg::*;

    // nothing pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending or input blocked after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // line end reports always close the results of their byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_LINE_OK || o_kind == KIND_UNTERM ||
                    o_kind == KIND_OVERLONG) |-> o_last_of_run)
        else $error("line end report not last of its byte");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_LINE_OK |-> o_token_count <= CTOK_MAX_TOKENS)
        else $error("token count above limit");

    // a token start that is not last is followed by a char of the same token
    a_start_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_kind == KIND_START && !o_last_of_run
        |=> o_valid && o_kind == KIND_CHAR && o_token_index == $past(o_token_index))
        else $error("token start not followed by its char");

endmodule

bind command_line_tokenizer_unit ctok_props u_ctok_props (.*);
